### hw/rtl/ssbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssbr_pkg;

  localparam int NUM_SETS    = 2048;
  localparam int NUM_WAYS    = 16;
  localparam int SIG_ENTRIES = 1024;

  localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WIDX_W = $clog2(NUM_WAYS);
  localparam int SIG_W  = $clog2(SIG_ENTRIES);

  localparam int CLR_DEPTH = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
  localparam int CLR_W     = $clog2(CLR_DEPTH);

  localparam int MASK_W = 16;
  localparam int WAY_W  = 5;

  localparam logic       REQ_VICTIM     = 1'b0;
  localparam logic       REQ_UPDATE     = 1'b1;
  localparam logic [1:0] KIND_WRITEBACK = 2'd3;

  localparam logic [1:0] RRPV_MAX  = 2'd3;
  localparam logic [1:0] RRPV_LONG = 2'd2;
  localparam logic [1:0] RRPV_NEAR = 2'd0;

  localparam logic [1:0] CNT_MAX  = 2'd3;
  localparam logic [1:0] CNT_MIN  = 2'd0;
  localparam logic [1:0] CNT_INIT = 2'd1;
  localparam logic [1:0] CNT_HOT  = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic [10:0]       set_index;
    logic [63:0]       pc;
    logic [1:0]        access_kind;
    logic [MASK_W-1:0] valid_mask;
    logic [WAY_W-1:0]  way;
    logic              hit;
  } in_word_t;

  typedef struct packed {
    logic [WAY_W-1:0] victim_way;
    logic             bypass;
  } out_word_t;

  typedef struct packed {
    logic [1:0]       rrpv;
    logic [SIG_W-1:0] sig;
    logic             reused;
  } line_t;

  typedef line_t [NUM_WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  localparam line_t LINE_RESET = '{rrpv: RRPV_MAX, sig: '0, reused: 1'b0};
  localparam row_t  ROW_RESET  = {NUM_WAYS{LINE_RESET}};

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_TRAIN
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/ssbr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ssbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ssbr_victim.sv
`timescale 1ns / 1ps
`default_nettype none

module ssbr_victim (
  input  wire ssbr_pkg::row_t                     row,
  input  wire logic [ssbr_pkg::MASK_W-1:0]        valid_mask,
  output logic      [ssbr_pkg::WAY_W-1:0]         victim_way,
  output logic                                    all_valid,
  output ssbr_pkg::row_t                          aged_row
);

  logic [ssbr_pkg::NUM_WAYS-1:0] vld;
  logic [ssbr_pkg::NUM_WAYS-1:0] has_val [4];
  logic [1:0]                    top;
  logic [1:0]                    add;
  logic [ssbr_pkg::WAY_W-1:0]    inv_way;
  logic [ssbr_pkg::WAY_W-1:0]    top_way;

  always_comb begin
    for (int w = 0; w < ssbr_pkg::NUM_WAYS; w++) begin
      vld[w] = (w < ssbr_pkg::MASK_W) ? valid_mask[w % ssbr_pkg::MASK_W] : 1'b1;
      for (int v = 0; v < 4; v++) begin
        has_val[v][w] = (row[w].rrpv == 2'(v));
      end
    end
    all_valid = &vld;

    if (|has_val[3]) begin
      top = 2'd3;
    end else if (|has_val[2]) begin
      top = 2'd2;
    end else if (|has_val[1]) begin
      top = 2'd1;
    end else begin
      top = 2'd0;
    end
    add = ssbr_pkg::RRPV_MAX - top;

    inv_way = '0;
    top_way = '0;
    for (int w = ssbr_pkg::NUM_WAYS - 1; w >= 0; w--) begin
      if (!vld[w]) begin
        inv_way = ssbr_pkg::WAY_W'(w);
      end
      if (row[w].rrpv == top) begin
        top_way = ssbr_pkg::WAY_W'(w);
      end
    end

    aged_row = row;
    for (int w = 0; w < ssbr_pkg::NUM_WAYS; w++) begin
      aged_row[w].rrpv = row[w].rrpv + add;
    end

    victim_way = all_valid ? top_way : inv_way;
  end

endmodule

`default_nettype wire

### hw/rtl/ship_srrip_bypass_replacement.sv
`timescale 1ns / 1ps
`default_nettype none

// Signature-based reuse prediction with 2-bit RRIP replacement and bypass.
// Input channel (in_valid/in_ready/in_word) carries victim requests and
// replacement updates. Output channel (out_valid/out_ready/out_word) carries
// one word per victim request: the chosen way, or the way count with bypass
// set. Updates produce no output word.
// Per-set line state (RRPV, signature, reused flag) sits in one set-wide
// SRAM row; the signature counters sit in a second SRAM. Each item reads
// its set row and counter in the accept cycle. The read state then writes
// back the aged row (victim request, no bypass, all ways valid) or the hit
// row; a miss fill reads the evicted line's counter there and writes row
// and counter in a train state. Victim words go to the output register
// from the read state. The output register lets the next item be accepted
// while a word waits; a victim request finding that register still full
// holds its read stage until out_ready. After reset a clearing pass
// initializes both SRAMs; in_ready stays low during it.
module ship_srrip_bypass_replacement (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ssbr_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ssbr_pkg::out_word_t      out_word
);

  ssbr_pkg::state_t state_r, state_nxt;
  logic [ssbr_pkg::CLR_W-1:0] clr_r, clr_nxt;
  logic out_valid_r, out_valid_nxt;
  ssbr_pkg::out_word_t out_word_r;
  ssbr_pkg::in_word_t  item_r;
  logic [1:0] shct_sig_r;

  logic                          set_we, set_re;
  logic [ssbr_pkg::SET_W-1:0]    set_waddr, set_raddr;
  ssbr_pkg::row_t                set_wdata;
  logic [ssbr_pkg::ROW_W-1:0]    set_rdata;
  logic                          shct_we, shct_re;
  logic [ssbr_pkg::SIG_W-1:0]    shct_waddr, shct_raddr;
  logic [1:0]                    shct_wdata, shct_rdata;

  ssbr_pkg::row_t             row_q, hit_row, fill_row, aged_row;
  ssbr_pkg::line_t            cur_line;
  logic [ssbr_pkg::WIDX_W-1:0] way_idx;
  logic [ssbr_pkg::SIG_W-1:0] item_sig, in_sig, old_sig;
  logic [ssbr_pkg::SET_W-1:0] item_set;
  logic [ssbr_pkg::WAY_W-1:0] vic_way;
  logic all_valid, bypass_c, upd_ok, out_free, out_load, clr_last;
  logic clr_in_sets, clr_in_sig;
  logic [1:0] trained, sig_cnt;

  ssbr_ram #(.WIDTH(ssbr_pkg::ROW_W), .DEPTH(ssbr_pkg::NUM_SETS)) u_set_ram (
    .clk   (clk),
    .we    (set_we),
    .waddr (set_waddr),
    .wdata (set_wdata),
    .re    (set_re),
    .raddr (set_raddr),
    .rdata (set_rdata)
  );

  ssbr_ram #(.WIDTH(2), .DEPTH(ssbr_pkg::SIG_ENTRIES)) u_shct_ram (
    .clk   (clk),
    .we    (shct_we),
    .waddr (shct_waddr),
    .wdata (shct_wdata),
    .re    (shct_re),
    .raddr (shct_raddr),
    .rdata (shct_rdata)
  );

  ssbr_victim u_victim (
    .row        (row_q),
    .valid_mask (item_r.valid_mask),
    .victim_way (vic_way),
    .all_valid  (all_valid),
    .aged_row   (aged_row)
  );

  always_comb begin
    row_q    = ssbr_pkg::row_t'(set_rdata);
    way_idx  = item_r.way[ssbr_pkg::WIDX_W-1:0];
    cur_line = row_q[way_idx];
    old_sig  = cur_line.sig;
    item_sig = item_r.pc[ssbr_pkg::SIG_W+1:2];
    in_sig   = in_word.pc[ssbr_pkg::SIG_W+1:2];
    item_set = item_r.set_index[ssbr_pkg::SET_W-1:0];
    bypass_c = (item_r.access_kind != ssbr_pkg::KIND_WRITEBACK) &&
               (shct_rdata == ssbr_pkg::CNT_MIN);
    upd_ok   = {1'b0, item_r.way} < (ssbr_pkg::WAY_W + 1)'(ssbr_pkg::NUM_WAYS);
    out_free = !out_valid_r || out_ready;
    clr_last = (clr_r == ssbr_pkg::CLR_W'(ssbr_pkg::CLR_DEPTH - 1));
    clr_in_sets = {1'b0, clr_r} < (ssbr_pkg::CLR_W + 1)'(ssbr_pkg::NUM_SETS);
    clr_in_sig  = {1'b0, clr_r} < (ssbr_pkg::CLR_W + 1)'(ssbr_pkg::SIG_ENTRIES);

    if (cur_line.reused) begin
      trained = (shct_rdata != ssbr_pkg::CNT_MAX) ? shct_rdata + 2'd1 : shct_rdata;
    end else begin
      trained = (shct_rdata != ssbr_pkg::CNT_MIN) ? shct_rdata - 2'd1 : shct_rdata;
    end
    sig_cnt = (old_sig == item_sig) ? trained : shct_sig_r;

    hit_row = row_q;
    hit_row[way_idx] = '{rrpv: ssbr_pkg::RRPV_NEAR, sig: cur_line.sig, reused: 1'b1};
    fill_row = row_q;
    fill_row[way_idx] = '{rrpv: (sig_cnt >= ssbr_pkg::CNT_HOT) ? ssbr_pkg::RRPV_NEAR
                                                               : ssbr_pkg::RRPV_LONG,
                          sig: item_sig, reused: 1'b0};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ssbr_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = ssbr_pkg::ST_IDLE;
        end
      end
      ssbr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ssbr_pkg::ST_READ;
        end
      end
      ssbr_pkg::ST_READ: begin
        if (item_r.req_type == ssbr_pkg::REQ_VICTIM) begin
          if (out_free) begin
            state_nxt = ssbr_pkg::ST_IDLE;
          end
        end else if (upd_ok && !item_r.hit) begin
          state_nxt = ssbr_pkg::ST_TRAIN;
        end else begin
          state_nxt = ssbr_pkg::ST_IDLE;
        end
      end
      ssbr_pkg::ST_TRAIN: begin
        state_nxt = ssbr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = ssbr_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    out_load   = 1'b0;
    set_we     = 1'b0;
    set_re     = 1'b0;
    set_waddr  = item_set;
    set_raddr  = in_word.set_index[ssbr_pkg::SET_W-1:0];
    set_wdata  = fill_row;
    shct_we    = 1'b0;
    shct_re    = 1'b0;
    shct_waddr = old_sig;
    shct_raddr = in_sig;
    shct_wdata = trained;
    clr_nxt    = clr_r;
    case (state_r)
      ssbr_pkg::ST_CLEAR: begin
        clr_nxt    = clr_r + 1'b1;
        set_we     = clr_in_sets;
        set_waddr  = clr_r[ssbr_pkg::SET_W-1:0];
        set_wdata  = ssbr_pkg::ROW_RESET;
        shct_we    = clr_in_sig;
        shct_waddr = clr_r[ssbr_pkg::SIG_W-1:0];
        shct_wdata = ssbr_pkg::CNT_INIT;
      end
      ssbr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        set_re   = in_valid;
        shct_re  = in_valid;
      end
      ssbr_pkg::ST_READ: begin
        if (item_r.req_type == ssbr_pkg::REQ_VICTIM) begin
          out_load  = out_free;
          set_we    = out_free && !bypass_c && all_valid;
          set_wdata = aged_row;
        end else if (upd_ok) begin
          if (item_r.hit) begin
            set_we    = 1'b1;
            set_wdata = hit_row;
          end else begin
            shct_re    = 1'b1;
            shct_raddr = old_sig;
          end
        end
      end
      ssbr_pkg::ST_TRAIN: begin
        set_we  = 1'b1;
        shct_we = 1'b1;
      end
      default: begin
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssbr_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_word;
    end
    if (state_r == ssbr_pkg::ST_READ) begin
      shct_sig_r <= shct_rdata;
    end
    if (out_load) begin
      out_word_r.victim_way <= bypass_c ? ssbr_pkg::WAY_W'(ssbr_pkg::NUM_WAYS) : vic_way;
      out_word_r.bypass     <= bypass_c;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire
